// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/qpq_pkg.sv =====
package qpq_pkg;

    // Default number of slots for the outer queue and for each packet.
    localparam int SLOTS_DEF = 8;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    // Operation codes as they arrive on the input stream.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    // Decoded command kinds handed from the front to the back.
    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_CLOSE  = 2'd1,
        K_POP    = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_OUTER_FULL  = 3'd1,
        ST_PACKET_FULL = 3'd2,
        ST_NOTHING     = 3'd3,
        ST_EMPTY_POP   = 3'd4
    } t_status;

    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      has_item;
        logic                      last;
        t_status                   status;
    } t_result;

endpackage

// ===== src/qpq_front.sv =====
module qpq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [qpq_pkg::OP_W-1:0]        i_op,
    input  logic signed [qpq_pkg::VALUE_W-1:0] i_value,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output qpq_pkg::t_cmd                   o_cmd
);
    import qpq_pkg::*;

    t_cmd       r_queue [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic       is_cmd;
    t_cmd       cmd;
    logic       push;
    logic       pop;

    // Classify the request; an unknown operation is taken and dropped.
    always_comb begin
        is_cmd      = 1'b1;
        cmd.value   = i_value;
        cmd.kind    = K_APPEND;
        unique case (i_op)
            OP_APPEND: cmd.kind = K_APPEND;
            OP_CLOSE:  cmd.kind = K_CLOSE;
            OP_POP:    cmd.kind = K_POP;
            default:   is_cmd   = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && is_cmd;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_queue[r_rp];

    // Two-entry command queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wp] <= cmd;
        end
    end

endmodule

// ===== src/qpq_back.sv =====
module qpq_back #(
    parameter int SLOTS = qpq_pkg::SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  qpq_pkg::t_cmd    i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output qpq_pkg::t_result o_out
);
    import qpq_pkg::*;

    localparam int PW    = $clog2(SLOTS);
    localparam int DEPTH = SLOTS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
    localparam logic [PW-1:0] LAST_P  = PW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic [PW-1:0]             r_oh, n_oh;
    logic [PW-1:0]             r_ot, n_ot;
    logic [PW-1:0]             r_open_len, n_open_len;
    logic [PW-1:0]             r_idx, n_idx;
    logic [PW-1:0]             r_len;
    logic [VALUE_W-1:0]        r_item_mem [DEPTH];
    logic [PW-1:0]             r_len_mem [SLOTS];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      out_free;
    logic                      load;
    t_result                   res;
    logic                      item_wr;
    logic                      len_wr;
    logic [PW-1:0]             idx_inc;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == LAST_P) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p,
                                                 input logic [PW-1:0] i);
        return AW'(p) * SLOTS_A + AW'(i);
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign idx_inc  = r_idx + PW'(1);

    // Sequencer: appends, closes and pops with nothing committed finish at once, any other pop walks its packet.
    always_comb begin
        n_state      = r_state;
        n_oh         = r_oh;
        n_ot         = r_ot;
        n_open_len   = r_open_len;
        n_idx        = r_idx;
        o_cmd_ready  = 1'b0;
        load         = 1'b0;
        item_wr      = 1'b0;
        len_wr       = 1'b0;
        res.value    = '0;
        res.has_item = 1'b0;
        res.last     = 1'b1;
        res.status   = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = out_free;
                if (i_cmd_valid && out_free) begin
                    unique case (i_cmd.kind)
                        K_APPEND: begin
                            load = 1'b1;
                            if (r_open_len == LAST_P) begin
                                res.status = ST_PACKET_FULL;
                            end else begin
                                item_wr    = 1'b1;
                                n_open_len = r_open_len + PW'(1);
                            end
                        end
                        K_CLOSE: begin
                            load = 1'b1;
                            if (nxt(r_ot) == r_oh) begin
                                res.status = ST_OUTER_FULL;
                            end else begin
                                len_wr     = 1'b1;
                                n_ot       = nxt(r_ot);
                                n_open_len = '0;
                            end
                        end
                        K_POP: begin
                            if (r_oh == r_ot) begin
                                load       = 1'b1;
                                res.status = ST_NOTHING;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_len == '0) begin
                        res.status = ST_EMPTY_POP;
                        n_oh       = nxt(r_oh);
                        n_state    = S_IDLE;
                    end else begin
                        res.value    = r_rd_data;
                        res.has_item = 1'b1;
                        res.last     = (idx_inc == r_len);
                        if (idx_inc == r_len) begin
                            n_idx   = '0;
                            n_oh    = nxt(r_oh);
                            n_state = S_IDLE;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oh        <= '0;
            r_ot        <= '0;
            r_open_len  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_oh       <= n_oh;
            r_ot       <= n_ot;
            r_open_len <= n_open_len;
            r_idx      <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    // Item memory: the open packet is written, the oldest packet is read ahead.
    always_ff @(posedge i_clk) begin
        if (item_wr) begin
            r_item_mem[slot_addr(r_ot, r_open_len)] <= i_cmd.value;
        end
        r_rd_data <= r_item_mem[slot_addr(r_oh, n_idx)];
    end

    // Packet length memory, written when a packet is committed.
    always_ff @(posedge i_clk) begin
        if (len_wr) begin
            r_len_mem[r_ot] <= r_open_len;
        end
        r_len <= r_len_mem[r_oh];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/queue_of_packet_queues_unit.sv =====
// Queue of packet queues. Requests arrive on the slave stream with the operation
// in tuser (0 append, 1 close, 2 pop) and the item in tdata; operation 3 is taken
// and gives no result. Up to SLOTS-1 committed packets are held, each of up to
// SLOTS-1 items, with item storage in one SLOTS*SLOTS-word memory and no clearing
// pass after reset. An append or a close is finished in the idle state of the back
// sequencer and gives one result. A pop first fetches the packet length from the
// length memory and then gives one item per cycle while the output register is
// free; the item memory's single read port sets that one-item-per-cycle pace.
// A two-entry command queue keeps accepting requests while a pop runs, and an
// output register holds each result until it is taken.
module queue_of_packet_queues_unit #(
    parameter int SLOTS = qpq_pkg::SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: item_value [31:0]
    input  logic signed [qpq_pkg::VALUE_W-1:0] i_s_axis_tdata,
    // tuser: operation [1:0]
    input  logic [qpq_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: out_value [31:0]
    output logic signed [qpq_pkg::VALUE_W-1:0] o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // tuser: has_item [0], status [3:1]
    output logic [qpq_pkg::STAT_W:0]           o_m_axis_tuser
);
    import qpq_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    t_cmd    cmd;
    t_result out;

    qpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    qpq_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (out)
    );

    assign o_m_axis_tdata = out.value;
    assign o_m_axis_tlast = out.last;
    assign o_m_axis_tuser = {out.status, out.has_item};

endmodule

// ===== src/qpq_checker.sv =====
`include "assert_macros.svh"

module qpq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic signed [qpq_pkg::VALUE_W-1:0] o_m_axis_tdata,
    input logic                               o_m_axis_tlast,
    input logic [qpq_pkg::STAT_W:0]           o_m_axis_tuser
);
    import qpq_pkg::*;

    logic                       no_item;
    logic                       with_item;
    logic                       stalled;
    logic [VALUE_W+STAT_W+1:0]  out_bus;

    // Qualified views of the result stream.
    assign no_item   = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign with_item = o_m_axis_tvalid && o_m_axis_tuser[0];
    assign stalled   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_bus   = {o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser};

    // A result without an item always ends its run.
    `ASSERT_IMPLY(a_no_item_last, i_clk, i_rst_n, no_item, o_m_axis_tlast)

    // A result without an item carries a zero value.
    `ASSERT_IMPLY(a_no_item_zero, i_clk, i_rst_n, no_item, o_m_axis_tdata == '0)

    // A popped item always reports a good status.
    `ASSERT_IMPLY(a_item_ok, i_clk, i_rst_n, with_item, o_m_axis_tuser[STAT_W:1] == ST_OK)

    // A stalled result holds until it is taken.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_m_axis_tvalid && $stable(out_bus))

endmodule

bind queue_of_packet_queues_unit qpq_checker u_qpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== sim/queue_of_packet_queues_unit_test.sv =====
`timescale 1ns / 100ps

module queue_of_packet_queues_unit_test;

    import qpq_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int PTR_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANDOM_ITEMS = 410;
    localparam int SETTLE_CYCLES = 40;
    // Operation code that the block takes and drops without a result.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef logic [PTR_W-1:0] t_slot;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        bit                        hold;
    } t_request;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic signed [VALUE_W-1:0]   s_data = '0;
    logic [OP_W-1:0]             s_user = '0;
    logic                        m_ready = 1'b0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic signed [VALUE_W-1:0]   o_m_axis_tdata;
    logic                        o_m_axis_tlast;
    logic [STAT_W:0]             o_m_axis_tuser;

    // Stimulus waiting to be driven and results the block still owes.
    t_request queued_requests[$];
    t_result  results_due[$];
    int       errors = 0;
    int       send_gap = 0;
    int       stall_left = 0;

    // Shadow copy of the packet queues.
    logic signed [VALUE_W-1:0] item_mem[SLOTS*SLOTS];
    t_slot                     pkt_head[SLOTS];
    t_slot                     pkt_tail[SLOTS];
    t_slot                     outer_head = '0;
    t_slot                     outer_tail = '0;

    queue_of_packet_queues_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    function automatic t_slot slot_next(input t_slot p);
        return (int'(p) == SLOTS - 1) ? t_slot'(0) : t_slot'(p + 1'b1);
    endfunction

    // Idle length: mostly short, a few long, and none at all during
    // every third stretch of simulated time.
    function automatic int idle_length();
        int pick;
        if ((($time / 1600) % 3) == 0) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return {1'b1, {(VALUE_W-1){1'b0}}};
            1: return {1'b0, {(VALUE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic owe_result(input logic signed [VALUE_W-1:0] value, input logic has_item,
                              input logic last, input t_status status);
        t_result r;
        r.value    = value;
        r.has_item = has_item;
        r.last     = last;
        r.status   = status;
        results_due.push_back(r);
    endtask

    // Update the shadow queues for one accepted request and record its results.
    task automatic apply_request(input logic [OP_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] value);
        t_slot tail;
        t_slot next_slot;
        t_slot h;
        t_slot t;
        case (op)
            OP_APPEND: begin
                tail = pkt_tail[outer_tail];
                if (slot_next(tail) == pkt_head[outer_tail]) begin
                    owe_result('0, 1'b0, 1'b1, ST_PACKET_FULL);
                end else begin
                    item_mem[int'(outer_tail) * SLOTS + int'(tail)] = value;
                    pkt_tail[outer_tail] = slot_next(tail);
                    owe_result('0, 1'b0, 1'b1, ST_OK);
                end
            end
            OP_CLOSE: begin
                next_slot = slot_next(outer_tail);
                if (next_slot == outer_head) begin
                    owe_result('0, 1'b0, 1'b1, ST_OUTER_FULL);
                end else begin
                    outer_tail = next_slot;
                    pkt_head[next_slot] = '0;
                    pkt_tail[next_slot] = '0;
                    owe_result('0, 1'b0, 1'b1, ST_OK);
                end
            end
            OP_POP: begin
                if (outer_head == outer_tail) begin
                    owe_result('0, 1'b0, 1'b1, ST_NOTHING);
                end else begin
                    h = pkt_head[outer_head];
                    t = pkt_tail[outer_head];
                    if (h == t) begin
                        owe_result('0, 1'b0, 1'b1, ST_EMPTY_POP);
                    end
                    while (h != t) begin
                        value = item_mem[int'(outer_head) * SLOTS + int'(h)];
                        h = slot_next(h);
                        owe_result(value, 1'b1, h == t, ST_OK);
                    end
                    pkt_head[outer_head] = h;
                    outer_head = slot_next(outer_head);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_request(input logic [OP_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] value, input bit hold);
        t_request r;
        r.op    = op;
        r.value = value;
        r.hold  = hold;
        queued_requests.push_back(r);
    endtask

    // Clock and reset.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: drive requests from the queue and predict each accepted one.
    always @(posedge i_clk) begin
        t_request next_req;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                apply_request(s_user, s_data);
            end
            if (!s_valid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() == 0 ||
                             (queued_requests[0].hold && results_due.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    next_req = queued_requests.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= next_req.value;
                    s_user  <= next_req.op;
                    send_gap = idle_length();
                end
            end
        end
    end

    // Receiver: stall the result stream at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 99) < 20) ? idle_length() : 0;
            m_ready <= (stall_left == 0);
        end
    end

    // Monitor: compare each taken result with the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: value %0d tuser %b", o_m_axis_tdata,
                       o_m_axis_tuser);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $error("out_value: expected %0d, got %0d", want.value, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser[0] !== want.has_item) begin
                    $error("has_item: expected %0d, got %0d", want.has_item,
                           o_m_axis_tuser[0]);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tuser[STAT_W:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           o_m_axis_tuser[STAT_W:1]);
                    errors++;
                end
            end
        end
    end

    // Stimulus and end of test.
    initial begin
        int random_count;
        int pick;
        int len;
        bit hold_done;
        random_count = 0;
        hold_done = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            pkt_head[i] = '0;
            pkt_tail[i] = '0;
        end

        // Directed: pop with nothing committed, the ignored code, a packet filled
        // with extreme values past its capacity, an empty packet, a pop of each packet and one pop too many.
        queue_request(OP_POP, '0, 1'b0);
        queue_request(OP_IGNORED, '1, 1'b0);
        queue_request(OP_APPEND, 32'sh7fffffff, 1'b0);
        queue_request(OP_APPEND, 32'sh80000000, 1'b0);
        queue_request(OP_APPEND, 32'sh00000000, 1'b0);
        queue_request(OP_APPEND, 32'shffffffff, 1'b0);
        queue_request(OP_APPEND, 32'sh55555555, 1'b0);
        queue_request(OP_APPEND, 32'shaaaaaaaa, 1'b0);
        queue_request(OP_APPEND, 32'sh00000001, 1'b0);
        queue_request(OP_APPEND, 32'sh12345678, 1'b0);
        queue_request(OP_CLOSE, '0, 1'b0);
        queue_request(OP_CLOSE, '1, 1'b0);
        queue_request(OP_POP, '0, 1'b1);
        queue_request(OP_POP, '0, 1'b0);
        queue_request(OP_POP, '0, 1'b0);
        // Close until the outer queue refuses one more packet.
        for (int i = 0; i < SLOTS; i++) begin
            queue_request(OP_CLOSE, '0, 1'b0);
        end

        // Random: mostly whole packets and pops, with some noise mixed in.
        while (random_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 99) < 15) ? $urandom_range(SLOTS - 1, SLOTS + 1)
                                                   : $urandom_range(0, SLOTS - 2);
                for (int i = 0; i < len; i++) begin
                    queue_request(OP_APPEND, pick_value(), 1'b0);
                end
                queue_request(OP_CLOSE, pick_value(), 1'b0);
                random_count += len + 1;
            end else if (pick < 85) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    queue_request(OP_POP, pick_value(), 1'b0);
                end
                random_count += len;
            end else if (pick < 90) begin
                len = $urandom_range(1, SLOTS);
                for (int i = 0; i < len; i++) begin
                    queue_request(OP_CLOSE, pick_value(), 1'b0);
                end
                random_count += len;
            end else if (pick < 95) begin
                queue_request(OP_IGNORED, pick_value(), 1'b0);
            end else begin
                queue_request(OP_W'(OP_APPEND + $urandom_range(0, 2)), pick_value(), 1'b0);
                random_count++;
            end
            // Once midway, hold the sender until the block has caught up.
            if (!hold_done && random_count >= RANDOM_ITEMS / 2) begin
                queue_request(OP_POP, '0, 1'b1);
                hold_done = 1'b1;
            end
        end

        @(posedge i_clk);
        while (!i_rst_n || queued_requests.size() != 0 || s_valid) begin
            @(posedge i_clk);
        end
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
